>>> hdl/sssu_pkg.sv
// Shared types and codes for the sorted string set union block.
package sssu_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_END    = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_FULL   = 3'd2,
    ST_LONG   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  localparam int unsigned CountOutW = 7;

endpackage

>>> hdl/sorted_string_set_union.sv
// Top level of the sorted string set union block.
// Builds words one character per request and keeps the distinct words in a
// table sorted byte-wise ascending (a prefix sorts first); equal words are
// dropped, so two word lists fed in turn give their sorted union. Words live
// in a character RAM of MAX_WORDS*MAX_CHARS bytes (one MAX_CHARS slot per
// word) and a length RAM of MAX_WORDS entries, both with registered reads.
// Append, clear and a read of an empty table give their result from the idle
// state; a read first looks up the length and character RAMs. An end-of-word
// request for an empty or overlong word also gives its result from the idle
// state; else it walks the table from the front, comparing the held words
// character by character, and stops on a duplicate or a full table. Otherwise
// it moves every slot at or after the insert point up by one, one byte per
// cycle, then the lengths, then writes the new slot byte by byte. The single
// read port of the character RAM makes the walk and the move go byte by byte.
// A result waits in an output register; a new request is taken while the
// previous one drains.
module sorted_string_set_union #(
  parameter int unsigned MAX_WORDS = 64,
  parameter int unsigned MAX_CHARS = 19
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [7:0]                     ch_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_char_o,
  output logic                           out_word_end_o,
  output logic                           out_last_o,
  output logic [2:0]                     status_o,
  output logic [sssu_pkg::CountOutW-1:0] word_count_o
);
  import sssu_pkg::*;

  localparam int unsigned Slots = MAX_WORDS * MAX_CHARS;
  localparam int unsigned AW    = $clog2(Slots);
  localparam int unsigned CW    = $clog2(Slots + 1);
  localparam int unsigned WW    = $clog2(MAX_WORDS);
  localparam int unsigned NW    = $clog2(MAX_WORDS + 1);
  localparam int unsigned LW    = $clog2(MAX_CHARS + 1);
  localparam int unsigned EIW   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SR_RD, S_SR_CK, S_SH_C, S_SH_L, S_WR
  } state_e;

  state_e        state_q;
  logic [NW-1:0] count_q;
  logic [CW-1:0] tot_base_q;   // count * MAX_CHARS
  logic [7:0]    entry_q [MAX_CHARS];
  logic [LW-1:0] elen_q;
  logic          ovf_q;
  logic [WW-1:0] rw_q;
  logic [CW-1:0] rbase_q;
  logic [LW-1:0] rc_q;
  logic [NW-1:0] pos_q;
  logic [CW-1:0] pos_base_q;
  logic [LW-1:0] ci_q;
  logic [CW-1:0] sh_addr_q;
  logic [NW-1:0] sh_w_q;
  logic          pend_q;
  logic [AW-1:0] pend_addr_q;
  logic [WW-1:0] pend_w_q;

  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          out_we_q;
  logic          out_last_q;
  logic [2:0]    out_status_q;
  logic [NW-1:0] out_count_q;

  // RAM ports
  logic          c_we;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [7:0]    c_wdata, c_rdata;
  logic          l_we;
  logic [WW-1:0] l_waddr, l_raddr;
  logic [LW-1:0] l_wdata, l_rdata;

  logic          accept;
  op_e           op;
  logic [LW-1:0] cmp_n;
  logic [7:0]    e_ch;

  assign op         = op_e'(op_i);
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign cmp_n      = (elen_q < l_rdata) ? elen_q : l_rdata;
  assign e_ch       = entry_q[ci_q[EIW-1:0]];

  sssu_ram #(.Width(8), .Depth(Slots)) u_chars (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  sssu_ram #(.Width(LW), .Depth(MAX_WORDS)) u_lens (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );

  // RAM address and write muxing by state
  always_comb begin
    c_raddr = AW'(rbase_q + CW'(rc_q));
    l_raddr = rw_q;
    c_we    = 1'b0;
    c_waddr = pend_addr_q;
    c_wdata = c_rdata;
    l_we    = 1'b0;
    l_waddr = pend_w_q;
    l_wdata = l_rdata;
    unique case (state_q)
      S_SR_RD: begin
        c_raddr = AW'(pos_base_q + CW'(ci_q));
        l_raddr = WW'(pos_q);
      end
      S_SH_C: begin
        c_raddr = AW'(sh_addr_q - CW'(1));
        c_we    = pend_q;
      end
      S_SH_L: begin
        l_raddr = WW'(sh_w_q - NW'(1));
        l_we    = pend_q;
      end
      S_WR: begin
        c_we    = 1'b1;
        c_waddr = AW'(pos_base_q + CW'(ci_q));
        c_wdata = e_ch;
        l_we    = (ci_q == '0);
        l_waddr = WW'(pos_q);
        l_wdata = elen_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && op == OP_APPEND && ch_i != 8'd0 && elen_q < LW'(MAX_CHARS)) begin
      entry_q[elen_q[EIW-1:0]] <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      tot_base_q   <= '0;
      elen_q       <= '0;
      ovf_q        <= 1'b0;
      rw_q         <= '0;
      rbase_q      <= '0;
      rc_q         <= '0;
      pos_q        <= '0;
      pos_base_q   <= '0;
      ci_q         <= '0;
      sh_addr_q    <= '0;
      sh_w_q       <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      pend_w_q     <= '0;
      out_valid_q  <= 1'b0;
      out_char_q   <= '0;
      out_we_q     <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= ST_OK;
      out_count_q  <= '0;
    end else begin
      // an accepted request sets or clears the result register itself
      if (out_valid_q && !out_stall_i && !accept) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_char_q   <= '0;
            out_we_q     <= 1'b0;
            out_last_q   <= 1'b0;
            unique case (op)
              OP_APPEND: begin
                out_valid_q  <= 1'b1;
                out_count_q  <= count_q;
                out_status_q <= (ch_i != 8'd0 && elen_q >= LW'(MAX_CHARS)) ? ST_LONG : ST_OK;
                if (ch_i != 8'd0) begin
                  if (elen_q < LW'(MAX_CHARS)) begin
                    elen_q <= elen_q + LW'(1);
                  end else begin
                    ovf_q <= 1'b1;
                  end
                end
              end
              OP_END: begin
                out_count_q <= count_q;
                if (ovf_q || elen_q == '0) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= ovf_q ? ST_LONG : ST_OK;
                  elen_q       <= '0;
                  ovf_q        <= 1'b0;
                end else begin
                  out_valid_q <= 1'b0;
                  pos_q      <= '0;
                  pos_base_q <= '0;
                  ci_q       <= '0;
                  pend_q     <= 1'b0;
                  sh_addr_q  <= tot_base_q;
                  // empty table: insert at the front straight away
                  state_q    <= (count_q == '0) ? S_SH_C : S_SR_RD;
                end
              end
              OP_READ: begin
                out_count_q <= count_q;
                if (count_q == '0) begin
                  out_valid_q  <= 1'b1;
                  out_status_q <= ST_EMPTY;
                end else begin
                  out_valid_q  <= 1'b0;
                  out_status_q <= ST_OK;
                  state_q      <= S_RD;
                end
              end
              OP_CLEAR: begin
                out_valid_q  <= 1'b1;
                out_status_q <= ST_OK;
                out_count_q  <= '0;
                count_q      <= '0;
                tot_base_q   <= '0;
                rw_q         <= '0;
                rbase_q      <= '0;
                rc_q         <= '0;
                elen_q       <= '0;
                ovf_q        <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          out_valid_q <= 1'b1;
          out_char_q  <= c_rdata;
          if ({1'b0, rc_q} + (LW+1)'(1) >= {1'b0, l_rdata}) begin
            out_we_q <= 1'b1;
            rc_q     <= '0;
            if (NW'(rw_q) + NW'(1) >= count_q) begin
              out_last_q <= 1'b1;
              rw_q       <= '0;
              rbase_q    <= '0;
            end else begin
              rw_q    <= rw_q + WW'(1);
              rbase_q <= rbase_q + CW'(MAX_CHARS);
            end
          end else begin
            rc_q <= rc_q + LW'(1);
          end
          state_q <= S_IDLE;
        end
        S_SR_RD: state_q <= S_SR_CK;
        S_SR_CK: begin
          priority if (ci_q < cmp_n && e_ch == c_rdata) begin
            ci_q    <= ci_q + LW'(1);
            state_q <= S_SR_RD;
          end else if ((ci_q < cmp_n) ? (e_ch < c_rdata) : (elen_q < l_rdata)) begin
            // entry sorts before this word: insert here
            if (count_q >= NW'(MAX_WORDS)) begin
              out_valid_q  <= 1'b1;
              out_status_q <= ST_FULL;
              elen_q       <= '0;
              state_q      <= S_IDLE;
            end else begin
              state_q <= S_SH_C;
            end
          end else if (ci_q >= cmp_n && elen_q == l_rdata) begin
            out_valid_q  <= 1'b1;
            out_status_q <= ST_DUP;
            elen_q       <= '0;
            state_q      <= S_IDLE;
          end else begin
            pos_q      <= pos_q + NW'(1);
            pos_base_q <= pos_base_q + CW'(MAX_CHARS);
            ci_q       <= '0;
            if (pos_q + NW'(1) == count_q) begin
              if (count_q >= NW'(MAX_WORDS)) begin
                out_valid_q  <= 1'b1;
                out_status_q <= ST_FULL;
                elen_q       <= '0;
                state_q      <= S_IDLE;
              end else begin
                state_q <= S_SH_C;
              end
            end else begin
              state_q <= S_SR_RD;
            end
          end
        end
        S_SH_C: begin
          // copy bytes downward, write lands one slot above in the following cycle
          if (sh_addr_q != pos_base_q) begin
            sh_addr_q   <= sh_addr_q - CW'(1);
            pend_q      <= 1'b1;
            pend_addr_q <= AW'(sh_addr_q - CW'(1) + CW'(MAX_CHARS));
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              sh_w_q  <= count_q;
              state_q <= S_SH_L;
            end
          end
        end
        S_SH_L: begin
          if (sh_w_q != pos_q) begin
            sh_w_q   <= sh_w_q - NW'(1);
            pend_q   <= 1'b1;
            pend_w_q <= WW'(sh_w_q);
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              ci_q    <= '0;
              state_q <= S_WR;
            end
          end
        end
        S_WR: begin
          if (ci_q == LW'(MAX_CHARS - 1)) begin
            count_q      <= count_q + NW'(1);
            tot_base_q   <= tot_base_q + CW'(MAX_CHARS);
            rw_q         <= '0;
            rbase_q      <= '0;
            rc_q         <= '0;
            elen_q       <= '0;
            out_valid_q  <= 1'b1;
            out_status_q <= ST_OK;
            out_count_q  <= count_q + NW'(1);
            state_q      <= S_IDLE;
          end else begin
            ci_q <= ci_q + LW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign out_word_end_o = out_we_q;
  assign out_last_o     = out_last_q;
  assign status_o       = out_status_q;
  assign word_count_o   = CountOutW'(out_count_q);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(MAX_WORDS))
    else $error("word count beyond table size");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> count_q != '0)
    else $error("table read with no words held");

  a_pend_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SH_C || state_q == S_SH_L))
    else $error("pending move outside shift phase");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> count_q < NW'(MAX_WORDS))
    else $error("insert into full table");

endmodule

>>> hdl/sssu_ram.sv
// Generic simple dual-port RAM with registered read.
module sssu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> verif/tb_top.sv
// Testbench for the sorted string set union block: directed table, random word lists, then a table fill.
`timescale 1ns / 100ps

module tb_top;
  import sssu_pkg::*;

  localparam int unsigned NWORDS = 64;
  localparam int unsigned NCHARS = 19;
  // Worst case per end-of-word request: full compare walk, shift, slot write.
  localparam int unsigned SLOW_REQ = 2 * NWORDS * (NCHARS + 1) + NWORDS * (NCHARS + 1) + 64;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic [7:0] oc;
    logic       we;
    logic       last;
    status_e    st;
    logic [6:0] cnt;
  } result_t;

  // Directed row: request, and an expected result only where it is obvious.
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       typed;
    result_t    res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] op_i = '0;
  logic [7:0] ch_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic out_word_end_o;
  logic out_last_o;
  logic [2:0] status_o;
  logic [CountOutW-1:0] word_count_o;

  sorted_string_set_union #(.MAX_WORDS(NWORDS), .MAX_CHARS(NCHARS)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: sorted word table plus the word under construction.
  logic [7:0] tbl_chars [NWORDS][NCHARS];
  int unsigned tbl_len [NWORDS];
  int unsigned tbl_cnt;
  logic [7:0] build_chars [NCHARS];
  int unsigned build_len;
  bit build_ovf;
  int unsigned rd_word, rd_char;

  result_t pending_q[$];
  int unsigned fail_cnt = 0;
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned items = 0;
  int unsigned base_items = 0;
  longint unsigned cyc = 0;

  // <0, 0, >0 as the word being built sorts before, equal to, after slot w.
  function automatic int cmp_build(int unsigned w);
    int unsigned n;
    n = build_len < tbl_len[w] ? build_len : tbl_len[w];
    for (int unsigned i = 0; i < n; i++)
      if (build_chars[i] != tbl_chars[w][i]) return build_chars[i] < tbl_chars[w][i] ? -1 : 1;
    if (build_len == tbl_len[w]) return 0;
    return build_len < tbl_len[w] ? -1 : 1;
  endfunction

  function automatic status_e insert_word();
    int unsigned pos;
    int c;
    pos = 0;
    c = 1;
    if (build_ovf) return ST_LONG;
    if (build_len == 0) return ST_OK;
    while (pos < tbl_cnt) begin
      c = cmp_build(pos);
      if (c <= 0) break;
      pos++;
    end
    if (pos < tbl_cnt && c == 0) return ST_DUP;
    if (tbl_cnt >= NWORDS) return ST_FULL;
    for (int unsigned k = tbl_cnt; k > pos; k--) begin
      tbl_chars[k] = tbl_chars[k-1];
      tbl_len[k] = tbl_len[k-1];
    end
    for (int unsigned i = 0; i < NCHARS; i++) tbl_chars[pos][i] = build_chars[i];
    tbl_len[pos] = build_len;
    tbl_cnt++;
    rd_word = 0;
    rd_char = 0;
    return ST_OK;
  endfunction

  function automatic result_t predict_union(op_e op, logic [7:0] ch);
    result_t r;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_APPEND: begin
        if (ch != 0) begin
          if (build_len < NCHARS) begin
            build_chars[build_len] = ch;
            build_len++;
          end else begin
            build_ovf = 1'b1;
            r.st = ST_LONG;
          end
        end
      end
      OP_END: begin
        r.st = insert_word();
        build_len = 0;
        build_ovf = 1'b0;
      end
      OP_READ: begin
        if (tbl_cnt == 0) begin
          r.st = ST_EMPTY;
        end else begin
          if (rd_word >= tbl_cnt) begin
            rd_word = 0;
            rd_char = 0;
          end
          if (rd_char >= tbl_len[rd_word]) rd_char = 0;
          r.oc = tbl_chars[rd_word][rd_char];
          if (rd_char + 1 >= tbl_len[rd_word]) begin
            r.we = 1'b1;
            if (rd_word + 1 >= tbl_cnt) begin
              r.last = 1'b1;
              rd_word = 0;
            end else begin
              rd_word++;
            end
            rd_char = 0;
          end else begin
            rd_char++;
          end
        end
      end
      default: begin
        tbl_cnt = 0;
        rd_word = 0;
        rd_char = 0;
        build_len = 0;
        build_ovf = 1'b0;
      end
    endcase
    r.cnt = tbl_cnt[6:0];
    return r;
  endfunction

  // Drive one request at the falling edge and hold it until taken.
  task automatic send_req(op_e op, logic [7:0] ch, bit typed, result_t want);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    r = predict_union(op, ch);
    if (typed && r !== want)
      $display("%0t: directed row mismatch, typed %p predicted %p", $time, want, r);
    pending_q.push_back(typed ? want : r);
    items++;
    in_valid_i <= 1'b1;
    op_i <= op;
    ch_i <= ch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Compare accepted results with the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result char=%h st=%0d", $time, out_char_o, status_o);
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_char_o !== exp_r.oc || out_word_end_o !== exp_r.we ||
            out_last_o !== exp_r.last || status_o !== exp_r.st || word_count_o !== exp_r.cnt) begin
          $display("%0t: mismatch exp char=%h we=%b last=%b st=%0d cnt=%0d", $time,
                   exp_r.oc, exp_r.we, exp_r.last, exp_r.st, exp_r.cnt);
          $display("%0t:          act char=%h we=%b last=%b st=%0d cnt=%0d", $time,
                   out_char_o, out_word_end_o, out_last_o, status_o, word_count_o);
          fail_cnt++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  // A random word, from a small alphabet when narrow so duplicates and prefixes occur.
  task automatic send_word(int unsigned len, bit narrow);
    for (int unsigned i = 0; i < len; i++)
      send_req(OP_APPEND, narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(1, 255)),
               1'b0, '0);
    send_req(OP_END, 8'($urandom), 1'b0, '0);
  endtask

  row_t dir_rows[$];

  initial begin
    tbl_cnt = 0;
    build_len = 0;
    build_ovf = 0;
    rd_word = 0;
    rd_char = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, zero byte, extreme bytes, prefix order, duplicate,
    // empty word, read wrap, overflow, clear.
    dir_rows = '{
      '{OP_READ,   8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, ST_EMPTY, 7'd0}},
      '{OP_APPEND, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK, 7'd0}},
      '{OP_APPEND, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK, 7'd0}},
      '{OP_END,    8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK, 7'd1}},
      '{OP_APPEND, 8'h01, 1'b0, '0},
      '{OP_APPEND, 8'h80, 1'b0, '0},
      '{OP_END,    8'h00, 1'b0, '0},
      '{OP_APPEND, 8'h01, 1'b0, '0},
      '{OP_END,    8'h00, 1'b0, '0},
      '{OP_APPEND, 8'h01, 1'b0, '0},
      '{OP_END,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, ST_DUP, 7'd3}},
      '{OP_END,    8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK, 7'd3}},
      '{OP_READ,   8'h55, 1'b0, '0},
      '{OP_READ,   8'hAA, 1'b0, '0},
      '{OP_READ,   8'h00, 1'b0, '0},
      '{OP_READ,   8'h00, 1'b0, '0},
      '{OP_READ,   8'h00, 1'b0, '0},
      '{OP_CLEAR,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK, 7'd0}}
    };
    foreach (dir_rows[i]) send_req(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].typed,
                                   dir_rows[i].res);
    // Overflow: twenty characters, the last rejected, then the word discarded.
    for (int i = 0; i < NCHARS; i++) send_req(OP_APPEND, 8'h7A, 1'b0, '0);
    send_req(OP_APPEND, 8'h7A, 1'b1, '{8'h00, 1'b0, 1'b0, ST_LONG, 7'd0});
    send_req(OP_END, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, ST_LONG, 7'd0});
    // A full-length word is still accepted.
    for (int i = 0; i < NCHARS; i++) send_req(OP_APPEND, 8'h41, 1'b0, '0);
    send_req(OP_END, 8'h00, 1'b0, '0);
    wait_drained();

    // Random phases; the sender pauses to drain once between phases.
    base_items = items;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 13 : 0;
      stall_pct = (ph == 2) ? 51 : (ph == 3) ? 13 : 0;
      while (items < base_items + 50 * (ph + 1)) begin
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_word($urandom_range(1, 5), $urandom_range(1) == 1);
        end else if (pick < 80) begin
          send_word($urandom_range(1, NCHARS + 2), 1'b0);
        end else if (pick < 97) begin
          send_req(OP_READ, 8'($urandom), 1'b0, '0);
        end else if (pick < 99) begin
          send_req(op_e'($urandom_range(3)), 8'($urandom), 1'b0, '0);
        end else begin
          send_req(OP_CLEAR, 8'($urandom), 1'b0, '0);
        end
      end
      wait_drained();
    end

    // Fill the table to capacity with distinct words, then try one more.
    idle_pct = 0;
    stall_pct = 13;
    send_req(OP_CLEAR, 8'h00, 1'b0, '0);
    for (int w = 0; w <= NWORDS; w++) begin
      send_req(OP_APPEND, 8'(8'h30 + w), 1'b0, '0);
      send_req(OP_END, 8'h00, 1'b0, '0);
    end
    send_req(OP_APPEND, 8'h30, 1'b0, '0);
    send_req(OP_END, 8'h00, 1'b0, '0);
    repeat (NWORDS + 2) send_req(OP_READ, 8'h00, 1'b0, '0);

    wait_drained();
    stall_pct = 0;
    repeat (SLOW_REQ) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sssu_pkg.sv
hdl/sssu_ram.sv
hdl/sorted_string_set_union.sv
verif/tb_top.sv
